[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on aclk, reset by aresetn.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check only while out of reset
`define LST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check at every edge, reset included
`define LST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/lst_pkg.sv]
// ----------------------------------------------------------------------------
// lst_pkg
// Shared widths, constants, sequencer states and divider bundles of the
// latency statistics tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lst_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned IN_W          = 2 * DATA_W;
    localparam int unsigned OUT_W         = 10 * DATA_W;
    localparam int unsigned NUM_W         = 2 * DATA_W;
    localparam int unsigned DEN_W         = DATA_W + 1;
    localparam int unsigned BATCH_MAX_DEF = 16;

    localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_CLOSE  = 13'b0000000000010,
        ST_DIVW   = 13'b0000000000100,
        ST_DIVI   = 13'b0000000001000,
        ST_MINMAX = 13'b0000000010000,
        ST_ADDW   = 13'b0000000100000,
        ST_DIVMW  = 13'b0000001000000,
        ST_ADDI   = 13'b0000010000000,
        ST_DIVMI  = 13'b0000100000000,
        ST_CHKA   = 13'b0001000000000,
        ST_ADDA   = 13'b0010000000000,
        ST_DIVA   = 13'b0100000000000,
        ST_PUSH   = 13'b1000000000000
    } seq_state_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/latency_statistics_tracker.sv]
// ----------------------------------------------------------------------------
// latency_statistics_tracker
// Batch averages of work/idle samples with running min, max and means.
// ----------------------------------------------------------------------------
// Input beats carry one work and one idle sample; s_tuser marks a beat that
// holds a sample and s_tlast closes the batch. Up to BATCH_MAX samples per
// batch are summed; more are dropped. A beat without s_tlast leaves s_tready
// high. A closing beat starts the sequencer: up to five divisions on one
// radix-2 divider plus add and multiply steps; s_tready stays low from the
// closing beat until the result is loaded. Each closing beat yields one
// result beat on m_tdata. The result sits in an output register; the next
// batch is taken while it waits, and a later result only waits for m_tready
// when that register is still full. Reset clears sums, counters and means,
// sets both minimums to all ones and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_statistics_tracker #(
    parameter int unsigned BATCH_MAX = lst_pkg::BATCH_MAX_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // work_time, idle_time
    input  wire logic [lst_pkg::IN_W-1:0] s_tdata,
    // sample_present
    input  wire logic                     s_tuser,
    input  wire logic                     s_tlast,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // batch_work, batch_idle, work_minimum, work_maximum, work_mean,
    // work_high_mean, idle_minimum, idle_maximum, idle_mean, batches_seen
    output logic [lst_pkg::OUT_W-1:0]     m_tdata
);
    import lst_pkg::*;

    localparam int unsigned FILL_W = $clog2(BATCH_MAX + 1);
    localparam int unsigned ACC_W  = DATA_W + FILL_W;

    seq_state_t        state_reg;
    seq_state_t        state_next;

    logic [ACC_W-1:0]  work_acc_reg;
    logic [ACC_W-1:0]  idle_acc_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [DATA_W-1:0] work_low_reg;
    logic [DATA_W-1:0] work_high_reg;
    logic [DATA_W-1:0] idle_low_reg;
    logic [DATA_W-1:0] idle_high_reg;
    logic [DATA_W-1:0] work_avg_reg;
    logic [DATA_W-1:0] idle_avg_reg;
    logic [DATA_W-1:0] above_avg_reg;
    logic [DATA_W-1:0] batch_cnt_reg;
    logic [DATA_W-1:0] above_cnt_reg;
    logic [DATA_W-1:0] bw_reg;
    logic [DATA_W-1:0] bi_reg;
    logic [NUM_W-1:0]  prod_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic              start_reg;
    logic              m_tvalid_reg;
    logic [OUT_W-1:0]  m_tdata_reg;

    logic              take;
    logic              out_free;
    logic              above;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [NUM_W-1:0]  mul_prod;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    lst_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign div_req.start = start_reg;
    assign div_req.num   = num_reg;
    assign div_req.den   = den_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready && s_tuser && (fill_reg < FILL_W'(BATCH_MAX));
    assign out_free = !m_tvalid_reg || m_tready;
    assign above    = (bw_reg > work_avg_reg) || (above_cnt_reg == '0);

    always_comb begin
        mul_a = work_avg_reg;
        mul_b = batch_cnt_reg;
        if (state_reg == ST_DIVMW) begin
            mul_a = idle_avg_reg;
        end else if (state_reg == ST_CHKA) begin
            mul_a = above_avg_reg;
            mul_b = above_cnt_reg;
        end
    end

    assign mul_prod = NUM_W'(mul_a) * NUM_W'(mul_b);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tlast) state_next = ST_CLOSE;
            end
            ST_CLOSE:  state_next = (fill_reg == '0) ? ST_MINMAX : ST_DIVW;
            ST_DIVW: begin
                if (div_rsp.done) state_next = ST_DIVI;
            end
            ST_DIVI: begin
                if (div_rsp.done) state_next = ST_MINMAX;
            end
            ST_MINMAX: state_next = ST_ADDW;
            ST_ADDW:   state_next = ST_DIVMW;
            ST_DIVMW: begin
                if (div_rsp.done) state_next = ST_ADDI;
            end
            ST_ADDI:   state_next = ST_DIVMI;
            ST_DIVMI: begin
                if (div_rsp.done) state_next = ST_CHKA;
            end
            ST_CHKA:   state_next = above ? ST_ADDA : ST_PUSH;
            ST_ADDA:   state_next = ST_DIVA;
            ST_DIVA: begin
                if (div_rsp.done) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            work_acc_reg  <= '0;
            idle_acc_reg  <= '0;
            fill_reg      <= '0;
            work_low_reg  <= ALL_ONES;
            work_high_reg <= '0;
            idle_low_reg  <= ALL_ONES;
            idle_high_reg <= '0;
            work_avg_reg  <= '0;
            idle_avg_reg  <= '0;
            above_avg_reg <= '0;
            batch_cnt_reg <= '0;
            above_cnt_reg <= '0;
        end else begin
            state_reg <= state_next;
            start_reg <= 1'b0;
            if ((state_reg == ST_PUSH) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg) inside
                ST_IDLE: begin
                    if (take) begin
                        work_acc_reg <= work_acc_reg + ACC_W'(s_tdata[DATA_W-1:0]);
                        idle_acc_reg <= idle_acc_reg + ACC_W'(s_tdata[IN_W-1:DATA_W]);
                        fill_reg     <= fill_reg + FILL_W'(1);
                    end
                end
                ST_CLOSE: begin
                    if (fill_reg != '0) start_reg <= 1'b1;
                end
                ST_DIVW: begin
                    if (div_rsp.done) start_reg <= 1'b1;
                end
                ST_DIVI: begin
                end
                ST_MINMAX: begin
                    if (bw_reg < work_low_reg)  work_low_reg  <= bw_reg;
                    if (bw_reg > work_high_reg) work_high_reg <= bw_reg;
                    if (bi_reg < idle_low_reg)  idle_low_reg  <= bi_reg;
                    if (bi_reg > idle_high_reg) idle_high_reg <= bi_reg;
                    work_acc_reg <= '0;
                    idle_acc_reg <= '0;
                    fill_reg     <= '0;
                end
                ST_ADDW, ST_ADDI, ST_ADDA: begin
                    start_reg <= 1'b1;
                end
                ST_DIVMW: begin
                    if (div_rsp.done) work_avg_reg <= div_rsp.quot;
                end
                ST_DIVMI: begin
                    if (div_rsp.done) begin
                        idle_avg_reg <= div_rsp.quot;
                        if (batch_cnt_reg != ALL_ONES) begin
                            batch_cnt_reg <= batch_cnt_reg + DATA_W'(1);
                        end
                    end
                end
                ST_CHKA: begin
                end
                ST_DIVA: begin
                    if (div_rsp.done) begin
                        above_avg_reg <= div_rsp.quot;
                        if (above_cnt_reg != ALL_ONES) begin
                            above_cnt_reg <= above_cnt_reg + DATA_W'(1);
                        end
                    end
                end
                ST_PUSH: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg) inside
            ST_CLOSE: begin
                num_reg <= NUM_W'(work_acc_reg);
                den_reg <= DEN_W'(fill_reg);
                bw_reg  <= '0;
                bi_reg  <= '0;
            end
            ST_DIVW: begin
                if (div_rsp.done) begin
                    bw_reg  <= div_rsp.quot;
                    num_reg <= NUM_W'(idle_acc_reg);
                end
            end
            ST_DIVI: begin
                if (div_rsp.done) bi_reg <= div_rsp.quot;
            end
            ST_MINMAX, ST_CHKA: begin
                prod_reg <= mul_prod;
            end
            ST_DIVMW: begin
                if (div_rsp.done) prod_reg <= mul_prod;
            end
            ST_ADDW: begin
                num_reg <= prod_reg + NUM_W'(bw_reg);
                den_reg <= {1'b0, batch_cnt_reg} + DEN_W'(1);
            end
            ST_ADDI: begin
                num_reg <= prod_reg + NUM_W'(bi_reg);
                den_reg <= {1'b0, batch_cnt_reg} + DEN_W'(1);
            end
            ST_ADDA: begin
                num_reg <= prod_reg + NUM_W'(bw_reg);
                den_reg <= {1'b0, above_cnt_reg} + DEN_W'(1);
            end
            ST_PUSH: begin
                if (out_free) begin
                    m_tdata_reg <= {batch_cnt_reg, idle_avg_reg, idle_high_reg,
                                    idle_low_reg, above_avg_reg, work_avg_reg,
                                    work_high_reg, work_low_reg, bi_reg, bw_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

[hw/rtl/lst_divider.sv]
// ----------------------------------------------------------------------------
// lst_divider
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// DATA_W bits, so the upper half of the numerator seeds the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module lst_divider (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire lst_pkg::div_req_t req,
    output lst_pkg::div_rsp_t      rsp
);
    import lst_pkg::*;

    localparam int unsigned STEP_W = $clog2(DATA_W + 1);

    logic [DEN_W-1:0]  rem_reg;
    logic [DATA_W-1:0] low_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic [DEN_W-1:0]  rem_next;

    always_comb begin
        trial    = {rem_reg, low_reg[DATA_W-1]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(DATA_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= {1'b0, req.num[NUM_W-1:DATA_W]};
            low_reg <= req.num[DATA_W-1:0];
            den_reg <= req.den;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[DATA_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = low_reg;

endmodule

`default_nettype wire

[hw/rtl/lst_checker.sv]
// ----------------------------------------------------------------------------
// lst_checker
// Port-level checks of the latency statistics tracker, bound to its top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lst_checker (
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_tvalid,
    input wire logic                      s_tready,
    input wire logic                      s_tlast,
    input wire logic                      m_tvalid,
    input wire logic                      m_tready,
    input wire logic [lst_pkg::OUT_W-1:0] m_tdata
);

    `LST_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `LST_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    `LST_ASSERT_ALWAYS(a_reset_state, !aresetn |=> s_tready && !m_tvalid, "not idle after reset")
    `LST_ASSERT(a_close_busy, s_tvalid && s_tready && s_tlast |=> !s_tready, "ready after closing beat")
    `LST_ASSERT(a_min_max, m_tvalid |-> (m_tdata[95:64] <= m_tdata[31:0]) && (m_tdata[31:0] <= m_tdata[127:96]), "batch work outside min and max")

endmodule

bind latency_statistics_tracker lst_checker u_lst_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[sim/tb_latency_statistics_tracker.sv]
// ----------------------------------------------------------------------------
// tb_latency_statistics_tracker
// Streams batches of work/idle samples into the tracker and checks every
// result beat, field by field, against a cycle-free model of the batch
// averages, extremes and running means kept inside this bench. A directed
// table covers empty, overlong and full-scale batches; random batches follow.
// Both channels pause at random, and the result side holds off once for long
// enough to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_latency_statistics_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    import lst_pkg::*;

    localparam int          CLK_PERIOD  = 8;
    localparam int unsigned BATCH_CAP   = BATCH_MAX_DEF;
    localparam int          ITEM_TARGET = 900;
    localparam int          CALM_TAIL   = 150;
    localparam int          SINK_HOLD   = 600;
    localparam int          QUIET_LIMIT = 4000;
    localparam int          DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [DATA_W-1:0] batches_seen;
        logic [DATA_W-1:0] idle_mean;
        logic [DATA_W-1:0] idle_maximum;
        logic [DATA_W-1:0] idle_minimum;
        logic [DATA_W-1:0] work_high_mean;
        logic [DATA_W-1:0] work_mean;
        logic [DATA_W-1:0] work_maximum;
        logic [DATA_W-1:0] work_minimum;
        logic [DATA_W-1:0] batch_idle;
        logic [DATA_W-1:0] batch_work;
    } stats_t;

    typedef struct {
        logic [DATA_W-1:0] work;
        logic [DATA_W-1:0] idle;
        bit                present;
        bit                last;
        int                reps;
        bit                known;
        stats_t            want;
    } directed_row_t;

    localparam stats_t FIRST_EMPTY = '{batches_seen: 32'd1, default: '0};
    localparam stats_t FULL_SCALE  = '{
        batches_seen:   32'd2,
        idle_mean:      32'h7FFF_FFFF,
        idle_maximum:   ALL_ONES,
        idle_minimum:   32'd0,
        work_high_mean: 32'h7FFF_FFFF,
        work_mean:      32'h7FFF_FFFF,
        work_maximum:   ALL_ONES,
        work_minimum:   32'd0,
        batch_idle:     ALL_ONES,
        batch_work:     ALL_ONES
    };

    directed_row_t directed_rows [10] = '{
        '{32'h0,         32'h0,         1'b0, 1'b1, 1,  1'b1, FIRST_EMPTY},
        '{ALL_ONES,      ALL_ONES,      1'b1, 1'b1, 1,  1'b1, FULL_SCALE},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, 1,  1'b0, '0},
        '{ALL_ONES,      ALL_ONES,      1'b1, 1'b0, 17, 1'b0, '0},
        '{32'h0000_0001, 32'h0000_0002, 1'b1, 1'b1, 1,  1'b0, '0},
        '{32'd100,       32'd7,         1'b1, 1'b1, 1,  1'b0, '0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, 1,  1'b0, '0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 1,  1'b0, '0},
        '{32'h0,         32'h0,         1'b1, 1'b1, 1,  1'b0, '0},
        '{32'h0F0F_F0F0, 32'hF0F0_0F0F, 1'b0, 1'b1, 1,  1'b0, '0}
    };

    string stat_names [10] = '{
        "batch_work", "batch_idle", "work_minimum", "work_maximum", "work_mean",
        "work_high_mean", "idle_minimum", "idle_maximum", "idle_mean", "batches_seen"
    };

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              s_tuser  = 1'b0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // model of the tracker
    logic [36:0]       work_sum     = '0;
    logic [36:0]       idle_sum     = '0;
    int unsigned       fill         = 0;
    logic [DATA_W-1:0] work_lo      = ALL_ONES;
    logic [DATA_W-1:0] work_hi      = '0;
    logic [DATA_W-1:0] idle_lo      = ALL_ONES;
    logic [DATA_W-1:0] idle_hi      = '0;
    logic [DATA_W-1:0] work_avg     = '0;
    logic [DATA_W-1:0] idle_avg     = '0;
    logic [DATA_W-1:0] busy_avg     = '0;
    logic [DATA_W-1:0] batches      = '0;
    logic [DATA_W-1:0] busy_batches = '0;

    stats_t stats_due [$];
    int     items_sent  = 0;
    int     mismatches  = 0;
    int     quiet_count = 0;
    int     sink_left   = 0;
    bit     gaps_on     = 1'b1;
    bit     hold_sink   = 1'b0;

    latency_statistics_tracker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [DATA_W-1:0] running_mean(
        input logic [DATA_W-1:0] mean,
        input logic [DATA_W-1:0] n,
        input logic [DATA_W-1:0] x
    );
        logic [63:0] num;
        logic [63:0] den;
        num = 64'(mean) * 64'(n) + 64'(x);
        den = 64'(n) + 64'd1;
        return DATA_W'(num / den);
    endfunction

    function automatic logic [DATA_W-1:0] bump(input logic [DATA_W-1:0] c);
        return (c == ALL_ONES) ? c : c + 32'd1;
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample(input logic [DATA_W-1:0] center);
        case ($urandom_range(0, 5))
            0:       return 32'(center + $urandom_range(0, 16) - 8);
            1:       return 32'($urandom_range(0, 255));
            2:       return ALL_ONES - 32'($urandom_range(0, 255));
            3:       return 32'($urandom_range(0, 100000));
            default: return 32'($urandom);
        endcase
    endfunction

    task automatic send_beat(
        input logic [DATA_W-1:0] w,
        input logic [DATA_W-1:0] d,
        input bit                present,
        input bit                last
    );
        logic [DATA_W-1:0] bw;
        logic [DATA_W-1:0] bi;
        stats_t            s;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d, w};
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);

        items_sent++;
        if (present && fill < BATCH_CAP) begin
            work_sum += w;
            idle_sum += d;
            fill++;
        end
        if (last) begin
            bw = (fill != 0) ? DATA_W'(work_sum / fill) : '0;
            bi = (fill != 0) ? DATA_W'(idle_sum / fill) : '0;
            work_sum = '0;
            idle_sum = '0;
            fill     = 0;
            if (bw < work_lo) work_lo = bw;
            if (bw > work_hi) work_hi = bw;
            if (bi < idle_lo) idle_lo = bi;
            if (bi > idle_hi) idle_hi = bi;
            work_avg = running_mean(work_avg, batches, bw);
            idle_avg = running_mean(idle_avg, batches, bi);
            batches  = bump(batches);
            if (bw > work_avg || busy_batches == 0) begin
                busy_avg     = running_mean(busy_avg, busy_batches, bw);
                busy_batches = bump(busy_batches);
            end
            s = '{
                batches_seen:   batches,
                idle_mean:      idle_avg,
                idle_maximum:   idle_hi,
                idle_minimum:   idle_lo,
                work_high_mean: busy_avg,
                work_mean:      work_avg,
                work_maximum:   work_hi,
                work_minimum:   work_lo,
                batch_idle:     bi,
                batch_work:     bw
            };
            stats_due.insert(stats_due.size(), s);
        end
        @(negedge aclk);
    endtask

    initial begin
        int  kind;
        int  len;
        bit  close_sample;
        int  loose;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r]) begin
            repeat (directed_rows[r].reps)
                send_beat(directed_rows[r].work, directed_rows[r].idle,
                          directed_rows[r].present, directed_rows[r].last);
            if (directed_rows[r].known) stats_due[$] = directed_rows[r].want;
        end

        hold_sink = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            gaps_on = (items_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 19);
            if (kind < 2)
                len = 0;
            else if (kind < 4)
                len = $urandom_range(BATCH_CAP + 1, BATCH_CAP + 6);
            else if (kind < 6)
                len = BATCH_CAP;
            else
                len = $urandom_range(1, 8);
            close_sample = (len > 0) && ($urandom_range(0, 1) == 1);
            loose = close_sample ? len - 1 : len;
            for (int i = 0; i < loose; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_beat($urandom, $urandom, 1'b0, 1'b0);
                send_beat(pick_sample(work_avg), pick_sample(idle_avg), 1'b1, 1'b0);
            end
            if (close_sample)
                send_beat(pick_sample(work_avg), pick_sample(idle_avg), 1'b1, 1'b1);
            else
                send_beat($urandom, $urandom, 1'b0, 1'b1);
        end
        s_tvalid <= 1'b0;

        while (stats_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                hold_sink = 1'b0;
                sink_left = SINK_HOLD;
            end else if (sink_left == 0 && gaps_on && $urandom_range(0, 4) == 0) begin
                sink_left = $urandom_range(1, 7);
            end
            if (sink_left > 0) begin
                m_tready <= 1'b0;
                sink_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        logic [OUT_W-1:0] want_bits;
        if (aresetn && m_tvalid && m_tready) begin
            if (stats_due.size() == 0) begin
                $error("result beat with no batch closed: %h", m_tdata);
                mismatches++;
            end else begin
                want_bits = stats_due.pop_front();
                for (int f = 0; f < 10; f++) begin
                    if (m_tdata[f*DATA_W +: DATA_W] !== want_bits[f*DATA_W +: DATA_W]) begin
                        $error("%s expected %h got %h", stat_names[f],
                               want_bits[f*DATA_W +: DATA_W], m_tdata[f*DATA_W +: DATA_W]);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count == QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/lst_pkg.sv
hw/rtl/lst_divider.sv
hw/rtl/latency_statistics_tracker.sv
hw/rtl/lst_checker.sv
sim/tb_latency_statistics_tracker.sv
